// ===== src/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 encoder
// used by b64e_front, b64e_queue, b64e_back and the top level
// no dependencies

package b64e_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam logic [7:0]  PadChar    = 8'h3D;

   // one complete or final partial group, as handed from front to back
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  nbytes;   // bytes present in the group, 1 to 3
      logic        last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // standard alphabet: A-Z a-z 0-9 + /
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      begin
         if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
         end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
         end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
         end else if (v == 6'd62) begin
            c = 8'h2B;
         end else begin
            c = 8'h2F;
         end
         return c;
      end
   endfunction

endpackage

// ===== src/base64_stream_encoder_top.sv =====
// Streaming base64 encoder (standard alphabet, '=' padding). Bytes go in one
// per item with a flag on the final byte; each completed or final group comes
// out as four character items, the fourth marked group_end and, for the last
// group, message_end. The input side takes a byte every cycle while the
// two-entry group queue has room; the output side sends one character per
// cycle while the queue holds a group and rsp_stall is low. The byte that
// closes a group is written into the group queue, and its first character
// is then registered in the output stage.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.

module base64_stream_encoder_top import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_group_end,
   output logic       rsp_message_end
);

   q_stat_type q_stat;
   group_type  grp;
   group_type  head;
   logic       grp_push;
   logic       grp_pop;

   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .q_stat             (q_stat),
      .grp_push           (grp_push),
      .grp_out            (grp)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp),
      .pop       (grp_pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_stat          (q_stat),
      .pop             (grp_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_group_end   (rsp_group_end),
      .rsp_message_end (rsp_message_end)
   );

   // message end only ever closes a group
   a_mend_on_gend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_group_end)
      else $error("message_end without group_end");

   // front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(grp_push && q_stat.full))
      else $error("group pushed into full queue");

   // a pad before the group end is followed by another pad
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_out == PadChar) && !rsp_group_end
      |=> rsp_valid && (rsp_char_out == PadChar))
      else $error("pad not followed by pad");

   // a pop only happens on an empty-free queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      grp_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

// ===== src/b64e_front.sv =====
// b64e_front: takes message bytes, collects them into 3-byte groups
// and pushes complete or final groups to the group queue; uses b64e_pkg

module b64e_front import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   input  q_stat_type q_stat,
   output logic       grp_push,
   output group_type  grp_out
);

   logic [7:0] first_held_ff, first_held_in;
   logic [7:0] second_held_ff, second_held_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] cnt;
   logic       accept;
   logic       hold;

   always_comb begin
      req_stall      = q_stat.full;
      accept         = req_valid && !req_stall;
      cnt            = (fill_ff == 2'd3) ? 2'd2 : fill_ff;
      hold           = (cnt < 2'd2) && !req_end_of_message;
      grp_push       = accept && !hold;
      first_held_in  = first_held_ff;
      second_held_in = second_held_ff;
      fill_in        = fill_ff;
      grp_out.nbytes = cnt + 2'd1;
      grp_out.last   = req_end_of_message;
      case (cnt)
         2'd0: grp_out.word = {req_data_byte, 16'h0000};
         2'd1: grp_out.word = {first_held_ff, req_data_byte, 8'h00};
         default: grp_out.word = {first_held_ff, second_held_ff, req_data_byte};
      endcase
      if (accept) begin
         if (hold) begin
            if (cnt == 2'd0) begin
               first_held_in = req_data_byte;
            end else begin
               second_held_in = req_data_byte;
            end
            fill_in = cnt + 2'd1;
         end else begin
            first_held_in  = 8'h00;
            second_held_in = 8'h00;
            fill_in        = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_held_ff  <= 8'h00;
         second_held_ff <= 8'h00;
         fill_ff        <= 2'd0;
      end else begin
         first_held_ff  <= first_held_in;
         second_held_ff <= second_held_in;
         fill_ff        <= fill_in;
      end
   end

endmodule

// ===== src/b64e_queue.sv =====
// b64e_queue: two-entry group queue between front and back
// uses group_type and q_stat_type from b64e_pkg

module b64e_queue import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  group_type  push_data,
   input  logic       pop,
   output group_type  head,
   output q_stat_type q_stat
);

   localparam int unsigned PtrW = $clog2(QueueDepth);
   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   group_type         mem_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      q_stat.full  = (cnt_ff == CntW'(QueueDepth));
      q_stat.empty = (cnt_ff == '0);
      head         = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in       = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== src/b64e_back.sv =====
// b64e_back: turns the group at the queue head into four characters,
// one a cycle while rsp_stall is low, into a registered output stage; uses b64e_pkg

module b64e_back import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  group_type  head,
   input  q_stat_type q_stat,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_group_end,
   output logic       rsp_message_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       gend_ff, gend_in;
   logic       mend_ff, mend_in;
   logic       load;
   logic [5:0] slice;
   logic       pad;

   always_comb begin
      load = !q_stat.empty && (!valid_ff || !rsp_stall);
      pop  = load && (idx_ff == 2'd3);
      case (idx_ff)
         2'd0: slice = head.word[23:18];
         2'd1: slice = head.word[17:12];
         2'd2: slice = head.word[11:6];
         default: slice = head.word[5:0];
      endcase
      // third char pads for a lone byte, fourth for anything short of three
      pad = ((idx_ff == 2'd2) && (head.nbytes < 2'd2)) ||
            ((idx_ff == 2'd3) && (head.nbytes < 2'd3));
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      gend_in  = gend_ff;
      mend_in  = mend_ff;
      if (load) begin
         idx_in   = idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = pad ? PadChar : b64_char(slice);
         gend_in  = (idx_ff == 2'd3);
         mend_in  = (idx_ff == 2'd3) && head.last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      gend_ff <= gend_in;
      mend_ff <= mend_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_group_end   = gend_ff;
   assign rsp_message_end = mend_ff;

endmodule
